[rtl/risc_load_store_core_subset_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the load/store core subset unit
// Checks are sampled on the rising edge of clk and are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef RISC_LOAD_STORE_CORE_SUBSET_UNIT_ASSERT_SVH
`define RISC_LOAD_STORE_CORE_SUBSET_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rlsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared codes, step numbers and types of the load/store core subset.
// ----------------------------------------------------------------------------
package rlsc_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
  localparam logic [31:0] PC_STEP   = 32'd4;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  // Sequencer steps of a word held in the execute stage
  localparam logic [2:0] STEP_ADDR    = 3'd2;
  localparam logic [2:0] STEP_MEM0    = 3'd3;
  localparam logic [2:0] LAST_ONE     = 3'd0;
  localparam logic [2:0] LAST_WR_BYTE = 3'd3;
  localparam logic [2:0] LAST_RD_BYTE = 3'd4;
  localparam logic [2:0] LAST_SW      = 3'd6;
  localparam logic [2:0] LAST_LW      = 3'd7;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_WR_BYTE = 2'd1,
    CMD_RD_BYTE = 2'd2,
    CMD_RD_REG  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage
`default_nettype wire

[rtl/risc_load_store_core_subset_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_load_store_core_subset_unit
// Memory words (lw, sw, byte write, byte read) step through the two-multiply
// address wrap unit and the single byte-wide data memory port (one byte per
// cycle); ALU, halt, idle and register-read words use neither. The latter
// are taken one word per cycle while the result is not stalled; memory words
// hold the execute stage until their last step. Reset clears pc, halt flag,
// register file valid bits and out_valid; data memory keeps its contents.
// ----------------------------------------------------------------------------
module risc_load_store_core_subset_unit #(
  parameter int MEM_BYTES = rlsc_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] instr_word,
  input  wire logic [15:0] byte_addr,
  input  wire logic [7:0]  byte_value,
  input  wire logic [4:0]  reg_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      next_pc,
  output logic             halted,
  output logic             reg_written,
  output logic [4:0]       dest_reg,
  output logic [31:0]      dest_value,
  output logic [31:0]      read_value
);

  localparam int AW = $clog2(MEM_BYTES);

  // execute stage
  logic               in_acc;
  logic               s1_valid;
  logic               s1_done;
  logic               adv;
  logic               act;
  logic               finish;
  rlsc_pkg::cmd_t     s1_cmd;
  logic [31:0]        s1_iw;
  logic [15:0]        s1_baddr;
  logic [7:0]         s1_bval;
  logic [4:0]         s1_rsel;
  logic [2:0]         s1_step;
  logic [2:0]         last_step;
  logic [31:0]        pc;
  logic               halt_flag;

  // register file
  logic [4:0]         rf_addr_a;
  logic [4:0]         rf_addr_b;
  logic [31:0]        opa;
  logic [31:0]        opb;
  rlsc_pkg::rf_wr_t   rf_wr;

  // decode
  logic [5:0]         op;
  logic [4:0]         rs;
  logic [4:0]         rt;
  logic [4:0]         rd;
  logic [31:0]        simm;
  logic               exec_live;
  logic               is_halt;
  logic               do_exec;
  logic               is_r;
  logic               is_lw;
  logic               is_sw;
  logic               sw_live;
  logic               wr_rf;
  logic [4:0]         dreg;
  logic [31:0]        alu;
  logic [31:0]        dval;

  // data memory
  logic [7:0]         dmem [MEM_BYTES];
  logic [AW-1:0]      maddr;
  logic [AW-1:0]      maddr_inc;
  logic [AW-1:0]      wrap_addr;
  logic [31:0]        wrap_in;
  logic [7:0]         mem_q;
  logic [7:0]         mem_wdata;
  logic               mem_rd_en;
  logic               mem_wr_en;
  logic [1:0]         byte_k;
  logic [31:0]        acc;

  // result
  logic [31:0]        res_pc;
  logic               res_halt;
  logic [4:0]         res_dreg;
  logic [31:0]        res_dval;
  logic [31:0]        res_rval;

  assign in_acc   = in_valid && !in_stall;
  assign finish   = s1_step == last_step;
  assign s1_done  = s1_valid && finish && !(out_valid && out_stall);
  assign adv      = s1_valid && !finish;
  assign act      = adv || s1_done;
  assign in_stall = rst || (s1_valid && !s1_done);

  // read operands of the word that sits in the execute stage next cycle
  always_comb begin
    if (in_acc) begin
      rf_addr_a = (cmd == rlsc_pkg::CMD_RD_REG) ? reg_select : instr_word[25:21];
      rf_addr_b = instr_word[20:16];
    end else begin
      rf_addr_a = (s1_cmd == rlsc_pkg::CMD_RD_REG) ? s1_rsel : rs;
      rf_addr_b = rt;
    end
  end

  assign rf_wr.en   = s1_done && wr_rf;
  assign rf_wr.addr = dreg;
  assign rf_wr.data = dval;

  rlsc_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (rf_addr_a),
    .rd_addr_b (rf_addr_b),
    .wr        (rf_wr),
    .rd_data_a (opa),
    .rd_data_b (opb)
  );

  // decode and ALU
  always_comb begin
    op        = s1_iw[31:26];
    rs        = s1_iw[25:21];
    rt        = s1_iw[20:16];
    rd        = s1_iw[15:11];
    simm      = {{16{s1_iw[15]}}, s1_iw[15:0]};
    exec_live = (s1_cmd == rlsc_pkg::CMD_EXEC) && !halt_flag;
    is_halt   = s1_iw == rlsc_pkg::HALT_WORD;
    do_exec   = exec_live && !is_halt;
    is_r      = op == rlsc_pkg::OP_RTYPE;
    is_lw     = op == rlsc_pkg::OP_LW;
    is_sw     = op == rlsc_pkg::OP_SW;
    sw_live   = do_exec && is_sw;
    dreg      = is_r ? rd : rt;
    wr_rf     = do_exec && (is_r || is_lw) && (dreg != 5'd0);
    unique case (s1_iw[2:0])
      rlsc_pkg::FN_ADDU: alu = opa + opb;
      rlsc_pkg::FN_SUBU: alu = opa - opb;
      rlsc_pkg::FN_AND:  alu = opa & opb;
      rlsc_pkg::FN_OR:   alu = opa | opb;
      rlsc_pkg::FN_NOR:  alu = ~(opa | opb);
      default:           alu = '0;
    endcase
    dval = is_lw ? {acc[23:0], mem_q} : alu;
  end

  always_comb begin
    unique case (s1_cmd)
      rlsc_pkg::CMD_EXEC: begin
        if (do_exec && is_lw) begin
          last_step = rlsc_pkg::LAST_LW;
        end else if (sw_live) begin
          last_step = rlsc_pkg::LAST_SW;
        end else begin
          last_step = rlsc_pkg::LAST_ONE;
        end
      end
      rlsc_pkg::CMD_WR_BYTE: last_step = rlsc_pkg::LAST_WR_BYTE;
      rlsc_pkg::CMD_RD_BYTE: last_step = rlsc_pkg::LAST_RD_BYTE;
      rlsc_pkg::CMD_RD_REG:  last_step = rlsc_pkg::LAST_ONE;
    endcase
  end

  // address wrap: effective address for lw/sw, byte address for preload/dump
  assign wrap_in = (s1_cmd == rlsc_pkg::CMD_EXEC) ? opa + simm : {16'd0, s1_baddr};

  rlsc_addr_wrap #(
    .MEM_BYTES (MEM_BYTES)
  ) u_addr_wrap (
    .clk   (clk),
    .en    (act),
    .value (wrap_in),
    .addr  (wrap_addr)
  );

  assign maddr_inc = (maddr == AW'(MEM_BYTES - 1)) ? '0 : maddr + 1'b1;
  assign byte_k    = 2'(s1_step - rlsc_pkg::STEP_MEM0);
  assign mem_rd_en = act && (s1_step >= rlsc_pkg::STEP_MEM0) && (s1_step < last_step);
  assign mem_wr_en = act && (s1_step >= rlsc_pkg::STEP_MEM0) &&
                     (sw_live || s1_cmd == rlsc_pkg::CMD_WR_BYTE);

  // big-endian: first byte of a word is its top byte
  always_comb begin
    if (s1_cmd == rlsc_pkg::CMD_WR_BYTE) begin
      mem_wdata = s1_bval;
    end else begin
      unique case (byte_k)
        2'd0: mem_wdata = opb[31:24];
        2'd1: mem_wdata = opb[23:16];
        2'd2: mem_wdata = opb[15:8];
        2'd3: mem_wdata = opb[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      dmem[maddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      mem_q <= dmem[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (act && s1_step == rlsc_pkg::STEP_ADDR) begin
      maddr <= wrap_addr;
    end else if (act && s1_step >= rlsc_pkg::STEP_MEM0) begin
      maddr <= maddr_inc;
    end
    // collect load bytes as they return
    if (act) begin
      acc <= {acc[23:0], mem_q};
    end
  end

  // result of the word in the execute stage
  always_comb begin
    res_pc   = do_exec ? pc + rlsc_pkg::PC_STEP : pc;
    res_halt = halt_flag || (exec_live && is_halt);
    res_dreg = wr_rf ? dreg : 5'd0;
    res_dval = wr_rf ? dval : 32'd0;
    unique case (s1_cmd)
      rlsc_pkg::CMD_RD_BYTE: res_rval = {24'd0, mem_q};
      rlsc_pkg::CMD_RD_REG:  res_rval = opa;
      default:               res_rval = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_step   <= '0;
      pc        <= '0;
      halt_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
        s1_step  <= '0;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (adv) begin
        s1_step <= s1_step + 3'd1;
      end
      if (s1_done) begin
        pc        <= res_pc;
        halt_flag <= res_halt;
      end
      out_valid <= s1_done || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd   <= rlsc_pkg::cmd_t'(cmd);
      s1_iw    <= instr_word;
      s1_baddr <= byte_addr;
      s1_bval  <= byte_value;
      s1_rsel  <= reg_select;
    end
    if (s1_done) begin
      next_pc     <= res_pc;
      halted      <= res_halt;
      reg_written <= wr_rf;
      dest_reg    <= res_dreg;
      dest_value  <= res_dval;
      read_value  <= res_rval;
    end
  end

endmodule
`default_nettype wire

[rtl/rlsc_regfile.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_regfile
// 32x32 register file: two registered read ports, one write port, per-entry
// valid bits so unwritten registers read zero, and a bypass of the last write.
// ----------------------------------------------------------------------------
module rlsc_regfile (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [4:0]            rd_addr_a,
  input  wire logic [4:0]            rd_addr_b,
  input  wire rlsc_pkg::rf_wr_t      wr,
  output logic [31:0]                rd_data_a,
  output logic [31:0]                rd_data_b
);

  logic [31:0]      regs [32];
  logic [31:0]      valid;
  logic [31:0]      q_a;
  logic [31:0]      q_b;
  logic             v_a;
  logic             v_b;
  logic [4:0]       addr_a_q;
  logic [4:0]       addr_b_q;
  rlsc_pkg::rf_wr_t byp;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.addr] <= wr.data;
    end
    q_a      <= regs[rd_addr_a];
    q_b      <= regs[rd_addr_b];
    addr_a_q <= rd_addr_a;
    addr_b_q <= rd_addr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      v_a    <= 1'b0;
      v_b    <= 1'b0;
      byp.en <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
        byp            <= wr;
      end
      v_a <= valid[rd_addr_a];
      v_b <= valid[rd_addr_b];
    end
  end

  // a write at the same edge as the read is missed by the array: take the bypass
  assign rd_data_a = (byp.en && byp.addr == addr_a_q) ? byp.data : (v_a ? q_a : '0);
  assign rd_data_b = (byp.en && byp.addr == addr_b_q) ? byp.data : (v_b ? q_b : '0);

endmodule
`default_nettype wire

[rtl/rlsc_addr_wrap.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_addr_wrap
// Reduces a 32-bit byte address modulo MEM_BYTES: reciprocal multiply,
// back-multiply, then one compare and subtract on the remainder of the registered values.
// ----------------------------------------------------------------------------
module rlsc_addr_wrap #(
  parameter int MEM_BYTES = rlsc_pkg::MEM_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [31:0]                  value,
  output logic [$clog2(MEM_BYTES)-1:0]      addr
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = 33 - AW;
  localparam int MW = AW + 1;
  localparam longint unsigned RECIP_L = (64'd1 << 32) / MEM_BYTES;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [MW-1:0] MODV  = MW'(MEM_BYTES);
  localparam logic [31:0]   MOD32 = 32'(MEM_BYTES);

  logic [31+RW:0]    prod1;
  logic [31:0]       val1;
  logic [RW-1:0]     quot;
  logic [RW+MW-1:0]  prod2;
  logic [31:0]       back2;
  logic [31:0]       val2;
  logic [31:0]       rem;
  logic [31:0]       rem_fix;

  // quotient estimate is exact or one short, so the remainder stays below 2x
  assign quot  = prod1[31+RW:32];
  assign prod2 = (RW+MW)'(quot) * (RW+MW)'(MODV);

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= (32+RW)'(value) * (32+RW)'(RECIP);
      val1  <= value;
      back2 <= prod2[31:0];
      val2  <= val1;
    end
  end

  always_comb begin
    rem     = val2 - back2;
    rem_fix = (rem >= MOD32) ? rem - MOD32 : rem;
    addr    = rem_fix[AW-1:0];
  end

endmodule
`default_nettype wire

[rtl/rlsc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "risc_load_store_core_subset_unit_assert.svh"

module rlsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] next_pc,
  input wire logic        halted,
  input wire logic        reg_written,
  input wire logic [4:0]  dest_reg,
  input wire logic [31:0] dest_value,
  input wire logic [31:0] read_value
);

  // no register write: destination fields are zero
  `RLSC_ASSERT_NOW(a_no_write_zero, out_valid && !reg_written, dest_reg == 5'd0 && dest_value == 32'd0, "destination fields set without a register write")

  // a register write never targets r0 and never carries a dump value
  `RLSC_ASSERT_NOW(a_write_fields, out_valid && reg_written, dest_reg != 5'd0 && read_value == 32'd0, "register write to r0 or with a dump value")

  // a word that leaves the core halted cannot have written a register
  `RLSC_ASSERT_NOW(a_halt_no_write, out_valid && halted, !reg_written, "register write reported while halted")

  // hold a stalled result
  `RLSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(next_pc) && $stable(dest_value) && $stable(read_value), "stalled result changed")

  // result channel is empty right after reset
  `RLSC_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind risc_load_store_core_subset_unit rlsc_checker u_rlsc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .next_pc     (next_pc),
  .halted      (halted),
  .reg_written (reg_written),
  .dest_reg    (dest_reg),
  .dest_value  (dest_value),
  .read_value  (read_value)
);
`default_nettype wire
